// ===== src/tunrf_pkg.sv =====
// Shared constants, types and tables for the RF tune sequence core.
`timescale 1ns / 1ps

package tunrf_pkg;

	// Field widths
	localparam int FREQ_W  = 30;
	localparam int QUOT_W  = 11;   // whole MHz of a 30-bit frequency
	localparam int REM_W   = 20;   // Hz below the MHz
	localparam int WORD_W  = 16;
	localparam int FRAC_W  = 6;
	localparam int BYTE_W  = 8;

	// Divide by one million through a scaled reciprocal
	localparam int HZ_PER_MHZ  = 1000000;
	localparam int RECIP_SHIFT = 40;
	localparam int RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP_MHZ =
		RECIP_W'((64'd1 << RECIP_SHIFT) / HZ_PER_MHZ);
	localparam int PROD_W = FREQ_W + RECIP_W;
	localparam int QM_W   = QUOT_W + REM_W;
	localparam int RAW_W  = REM_W + 1;    // remainder before correction, below 2 MHz

	// Round-up threshold on the final remainder
	localparam int ROUND_THR = 7812;

	// One fraction step is a 64th of a MHz
	localparam int FRAC_STEPS = 1 << FRAC_W;
	localparam int FRAC_UNIT  = HZ_PER_MHZ / FRAC_STEPS;

	// Spur search
	localparam int SPUR_ENTRIES  = 17;
	localparam int DEFINED_SPURS = 17;
	localparam int KHZ           = 1000;

	// Number of writes in one sequence
	localparam int WRITES = 10;
	localparam int CNT_W  = 4;

	// Tuner register addresses
	localparam logic [BYTE_W-1:0] ADDR_TUNE_CTRL = 8'h13;
	localparam logic [BYTE_W-1:0] ADDR_SYN_CFG   = 8'h3B;
	localparam logic [BYTE_W-1:0] ADDR_SYN_MODE  = 8'h10;
	localparam logic [BYTE_W-1:0] ADDR_SYN_DIV   = 8'h1A;
	localparam logic [BYTE_W-1:0] ADDR_SPUR_VAL  = 8'h61;
	localparam logic [BYTE_W-1:0] ADDR_SPUR_DIR  = 8'h62;
	localparam logic [BYTE_W-1:0] ADDR_WORD_LO   = 8'h11;
	localparam logic [BYTE_W-1:0] ADDR_WORD_HI   = 8'h12;

	// Fixed register values
	localparam logic [BYTE_W-1:0] VAL_ABORT    = 8'h00;
	localparam logic [BYTE_W-1:0] VAL_CFG_A    = 8'hC0;
	localparam logic [BYTE_W-1:0] VAL_CFG_B    = 8'h80;
	localparam logic [BYTE_W-1:0] VAL_MODE     = 8'h95;
	localparam logic [BYTE_W-1:0] VAL_DIV      = 8'h05;
	localparam logic [BYTE_W-1:0] VAL_DIR_BASE = 8'hA0;
	localparam logic [BYTE_W-1:0] VAL_START    = 8'h01;
	localparam logic [BYTE_W-1:0] VAL_NO_SPUR  = 8'h00;

	// One spur window, bounds in Hz
	typedef struct packed {
		logic [FREQ_W-1:0] lo;
		logic [FREQ_W-1:0] hi;
		logic [BYTE_W-1:0] val;
		logic [BYTE_W-1:0] dir;
	} spur_win_t;

	// Outcome of the spur search
	typedef struct packed {
		logic              hit;
		logic [BYTE_W-1:0] val;
		logic [BYTE_W-1:0] dir;
	} spur_res_t;

	// Everything the sequencer needs for one item
	typedef struct packed {
		logic [WORD_W-1:0] word;
		spur_res_t         spur;
	} tune_item_t;

	function automatic spur_win_t mk_win(int center, int offset,
			logic [BYTE_W-1:0] val, logic [BYTE_W-1:0] dir);
		spur_win_t w;
		w.lo  = FREQ_W'((center - offset) * KHZ);
		w.hi  = FREQ_W'((center + offset) * KHZ);
		w.val = val;
		w.dir = dir;
		return w;
	endfunction

	// Spur window table; entries past the defined ones can never match
	function automatic spur_win_t spur_win(int idx);
		spur_win_t w;
		w.lo  = '1;
		w.hi  = '0;
		w.val = '0;
		w.dir = '0;
		case (idx)
			0:  w = mk_win( 64500, 500, 8'h92, 8'h07);
			1:  w = mk_win(191500, 300, 8'hE2, 8'h07);
			2:  w = mk_win(205500, 500, 8'h2C, 8'h04);
			3:  w = mk_win(212500, 500, 8'h1E, 8'h04);
			4:  w = mk_win(226500, 500, 8'hD4, 8'h07);
			5:  w = mk_win( 99143, 500, 8'h9C, 8'h07);
			6:  w = mk_win(173143, 500, 8'hD4, 8'h07);
			7:  w = mk_win(191143, 300, 8'hD4, 8'h07);
			8:  w = mk_win(207143, 500, 8'hCE, 8'h07);
			9:  w = mk_win(225143, 500, 8'hCE, 8'h07);
			10: w = mk_win(243143, 500, 8'hD4, 8'h07);
			11: w = mk_win(261143, 500, 8'hD4, 8'h07);
			12: w = mk_win(291143, 500, 8'hD4, 8'h07);
			13: w = mk_win(339143, 500, 8'h2C, 8'h04);
			14: w = mk_win(117143, 500, 8'h7A, 8'h07);
			15: w = mk_win(135143, 300, 8'h7A, 8'h07);
			16: w = mk_win(153143, 500, 8'h01, 8'h07);
			default: ;
		endcase
		return w;
	endfunction

endpackage

// ===== src/tunrf_word.sv =====
// Synthesizer word pipeline: MHz split, six fraction bits, rounding.
`timescale 1ns / 1ps

module tunrf_word (
	input  logic                          clk,
	input  logic [tunrf_pkg::FREQ_W-1:0]  freq_s1,
	output logic [tunrf_pkg::WORD_W-1:0]  word_s4
);

	logic [tunrf_pkg::PROD_W-1:0] prod_s2;
	logic [tunrf_pkg::FREQ_W-1:0] freq_s2;
	logic [tunrf_pkg::QUOT_W-1:0] quot_s3;
	logic [tunrf_pkg::RAW_W-1:0]  rem_raw_s3;
	logic [tunrf_pkg::QUOT_W-1:0] quot_est;
	logic [tunrf_pkg::QM_W-1:0]   quot_hz;
	logic [tunrf_pkg::WORD_W-1:0] word_d;

	// Stage 2: scale by the reciprocal of one million
	always_ff @(posedge clk) begin
		prod_s2 <= {{(tunrf_pkg::PROD_W-tunrf_pkg::FREQ_W){1'b0}}, freq_s1}
			* {{(tunrf_pkg::PROD_W-tunrf_pkg::RECIP_W){1'b0}}, tunrf_pkg::RECIP_MHZ};
		freq_s2 <= freq_s1;
	end

	// Quotient estimate, low by at most one
	assign quot_est = prod_s2[tunrf_pkg::RECIP_SHIFT +: tunrf_pkg::QUOT_W];
	assign quot_hz  = tunrf_pkg::QM_W'(quot_est) * tunrf_pkg::QM_W'(tunrf_pkg::HZ_PER_MHZ);

	// Stage 3: remainder of the estimate
	always_ff @(posedge clk) begin
		quot_s3    <= quot_est;
		rem_raw_s3 <= tunrf_pkg::RAW_W'({1'b0, freq_s2} - quot_hz);
	end

	// Correct the quotient, then fraction and round-up from parallel compares
	always_comb begin
		logic [tunrf_pkg::QUOT_W-1:0]  q;
		logic [tunrf_pkg::RAW_W-1:0]   r_raw;
		logic [tunrf_pkg::REM_W-1:0]   r;
		logic [tunrf_pkg::FRAC_W:0]    frac;
		logic [tunrf_pkg::WORD_W:0]    w;
		q     = quot_s3;
		r_raw = rem_raw_s3;
		if (r_raw >= tunrf_pkg::RAW_W'(tunrf_pkg::HZ_PER_MHZ)) begin
			r_raw = r_raw - tunrf_pkg::RAW_W'(tunrf_pkg::HZ_PER_MHZ);
			q     = q + 1'b1;
		end
		r = r_raw[tunrf_pkg::REM_W-1:0];
		// Halving strict compares leave fraction j with a rest in (0, one step];
		// the round-up adds one above 7812, so fraction plus round-up is the
		// count of steps j with the remainder above 7812 + j steps
		frac = '0;
		for (int j = 0; j < tunrf_pkg::FRAC_STEPS; j++) begin
			if (r > tunrf_pkg::REM_W'(tunrf_pkg::ROUND_THR + j * tunrf_pkg::FRAC_UNIT))
				frac = (tunrf_pkg::FRAC_W+1)'(j + 1);
		end
		w = ((tunrf_pkg::WORD_W+1)'(q) << tunrf_pkg::FRAC_W)
			+ (tunrf_pkg::WORD_W+1)'(frac);
		word_d = w[tunrf_pkg::WORD_W-1:0];
	end

	// Stage 4: finished word
	always_ff @(posedge clk) begin
		word_s4 <= word_d;
	end

endmodule

// ===== src/tunrf_spur.sv =====
// Spur window search with the result delayed to line up with the word.
`timescale 1ns / 1ps

module tunrf_spur (
	input  logic                          clk,
	input  logic [tunrf_pkg::FREQ_W-1:0]  freq_s1,
	output tunrf_pkg::spur_res_t          spur_s4
);

	tunrf_pkg::spur_res_t spur_d;
	tunrf_pkg::spur_res_t spur_s2;
	tunrf_pkg::spur_res_t spur_s3;

	// All windows compared at once; the lowest matching index wins
	always_comb begin
		tunrf_pkg::spur_win_t w;
		spur_d.hit = 1'b0;
		spur_d.val = tunrf_pkg::VAL_NO_SPUR;
		spur_d.dir = tunrf_pkg::VAL_NO_SPUR;
		for (int i = tunrf_pkg::SPUR_ENTRIES - 1; i >= 0; i--) begin
			w = tunrf_pkg::spur_win(i);
			if (freq_s1 >= w.lo && freq_s1 <= w.hi) begin
				spur_d.hit = 1'b1;
				spur_d.val = w.val;
				spur_d.dir = w.dir;
			end
		end
	end

	always_ff @(posedge clk) begin
		spur_s2 <= spur_d;
		spur_s3 <= spur_s2;
		spur_s4 <= spur_s3;
	end

endmodule

// ===== src/tunrf_seq.sv =====
// Write sequencer: plays out the ten register writes of one item.
`timescale 1ns / 1ps

module tunrf_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  tunrf_pkg::tune_item_t         item,
	output logic                          strobe,
	output logic [tunrf_pkg::BYTE_W-1:0]  reg_address,
	output logic [tunrf_pkg::BYTE_W-1:0]  reg_value,
	output logic                          spur_hit,
	output logic                          last
);

	// Position within the write sequence
	typedef enum logic [tunrf_pkg::CNT_W-1:0] {
		STEP_ABORT,
		STEP_CFG_A,
		STEP_CFG_B,
		STEP_MODE,
		STEP_DIV,
		STEP_SPUR_VAL,
		STEP_SPUR_DIR,
		STEP_WORD_LO,
		STEP_WORD_HI,
		STEP_START
	} step_t;

	tunrf_pkg::tune_item_t         item_q;
	step_t                         step_q;
	logic                          active_q;
	logic [tunrf_pkg::BYTE_W-1:0]  addr_d;
	logic [tunrf_pkg::BYTE_W-1:0]  val_d;

	// Address and value of the current write
	always_comb begin
		addr_d = tunrf_pkg::ADDR_TUNE_CTRL;
		val_d  = tunrf_pkg::VAL_ABORT;
		case (step_q)
			STEP_ABORT: begin
				addr_d = tunrf_pkg::ADDR_TUNE_CTRL;
				val_d  = tunrf_pkg::VAL_ABORT;
			end
			STEP_CFG_A: begin
				addr_d = tunrf_pkg::ADDR_SYN_CFG;
				val_d  = tunrf_pkg::VAL_CFG_A;
			end
			STEP_CFG_B: begin
				addr_d = tunrf_pkg::ADDR_SYN_CFG;
				val_d  = tunrf_pkg::VAL_CFG_B;
			end
			STEP_MODE: begin
				addr_d = tunrf_pkg::ADDR_SYN_MODE;
				val_d  = tunrf_pkg::VAL_MODE;
			end
			STEP_DIV: begin
				addr_d = tunrf_pkg::ADDR_SYN_DIV;
				val_d  = tunrf_pkg::VAL_DIV;
			end
			STEP_SPUR_VAL: begin
				addr_d = tunrf_pkg::ADDR_SPUR_VAL;
				val_d  = item_q.spur.val;
			end
			STEP_SPUR_DIR: begin
				addr_d = tunrf_pkg::ADDR_SPUR_DIR;
				val_d  = tunrf_pkg::VAL_DIR_BASE | item_q.spur.dir;
			end
			STEP_WORD_LO: begin
				addr_d = tunrf_pkg::ADDR_WORD_LO;
				val_d  = item_q.word[tunrf_pkg::BYTE_W-1:0];
			end
			STEP_WORD_HI: begin
				addr_d = tunrf_pkg::ADDR_WORD_HI;
				val_d  = item_q.word[tunrf_pkg::WORD_W-1:tunrf_pkg::BYTE_W];
			end
			STEP_START: begin
				addr_d = tunrf_pkg::ADDR_TUNE_CTRL;
				val_d  = tunrf_pkg::VAL_START;
			end
			default: ;
		endcase
	end

	// Sequence state, item hold and registered write;
	// a new item may load while the sequencer is on its final step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= STEP_ABORT;
			item_q      <= '0;
			strobe      <= 1'b0;
			reg_address <= '0;
			reg_value   <= '0;
			spur_hit    <= 1'b0;
			last        <= 1'b0;
		end else begin
			strobe      <= active_q;
			reg_address <= addr_d;
			reg_value   <= val_d;
			spur_hit    <= item_q.spur.hit;
			last        <= (step_q == STEP_START);
			if (load) begin
				active_q <= 1'b1;
				step_q   <= STEP_ABORT;
				item_q   <= item;
			end else if (active_q) begin
				if (step_q == STEP_START) begin
					active_q <= 1'b0;
					step_q   <= STEP_ABORT;
				end else begin
					step_q <= step_t'(step_q + 1'b1);
				end
			end
		end
	end

	// A new item never cuts into a running sequence
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!active_q || step_q == STEP_START))
		else $error("item loaded while sequence still running");

	// Writes of one item come on consecutive cycles
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside write sequence");

	// Final write is the start-tune command
	a_last_start: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> (reg_address == tunrf_pkg::ADDR_TUNE_CTRL
			&& reg_value == tunrf_pkg::VAL_START))
		else $error("final write is not start tune");

	// Spur flag is constant over one sequence
	a_hit_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> (spur_hit == $past(spur_hit)))
		else $error("spur flag changed within a sequence");

endmodule

// ===== src/tuner_rf_tune_sequence_core.sv =====
// Top level of the RF tune sequence core: handshake, pipeline valids, units.
`timescale 1ns / 1ps
//
//  channel   ports                                         direction
//  command   start, busy, rf_freq_hz                       in (busy out)
//  result    strobe, reg_address, reg_value, spur_hit, last out
//
//  An item is taken when start is high and busy is low. It yields ten writes on
//  consecutive cycles; strobe marks each. With start held, the next item is taken
//  while the writes of the last still come out, spaced by the busy counter, and
//  its writes follow them with no gap. busy goes high after each acceptance and
//  stays high until the counter runs down. Reset clears valids, the busy counter
//  and the sequencer. The receiver cannot stall; results are shown once each.

module tuner_rf_tune_sequence_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tunrf_pkg::FREQ_W-1:0]  rf_freq_hz,
	output logic                          strobe,
	output logic [tunrf_pkg::BYTE_W-1:0]  reg_address,
	output logic [tunrf_pkg::BYTE_W-1:0]  reg_value,
	output logic                          spur_hit,
	output logic                          last
);

	logic                          accept;
	logic [tunrf_pkg::CNT_W-1:0]   hold_q;
	logic [tunrf_pkg::FREQ_W-1:0]  freq_s1;
	logic                          vld_s1;
	logic                          vld_s2;
	logic                          vld_s3;
	logic                          vld_s4;
	logic [tunrf_pkg::WORD_W-1:0]  word_s4;
	tunrf_pkg::spur_res_t          spur_s4;
	tunrf_pkg::tune_item_t         item_s4;

	assign accept = start && !busy;
	assign busy   = (hold_q != '0);

	// Busy counter spaces items by the sequence length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (accept) begin
			hold_q <= tunrf_pkg::CNT_W'(tunrf_pkg::WRITES - 1);
		end else if (hold_q != '0) begin
			hold_q <= hold_q - 1'b1;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (accept)
			freq_s1 <= rf_freq_hz;
	end

	tunrf_word u_word (
		.clk     (clk),
		.freq_s1 (freq_s1),
		.word_s4 (word_s4)
	);

	tunrf_spur u_spur (
		.clk     (clk),
		.freq_s1 (freq_s1),
		.spur_s4 (spur_s4)
	);

	assign item_s4.word = word_s4;
	assign item_s4.spur = spur_s4;

	tunrf_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (vld_s4),
		.item        (item_s4),
		.strobe      (strobe),
		.reg_address (reg_address),
		.reg_value   (reg_value),
		.spur_hit    (spur_hit),
		.last        (last)
	);

	// Acceptance always raises busy for the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after acceptance");

	// Items are spaced far enough that only one is in the pipeline
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({vld_s1, vld_s2, vld_s3, vld_s4}) <= 1)
		else $error("more than one item in the pipeline");

	// Stage one is only filled while busy holds off the next item
	a_s1_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> busy)
		else $error("pipeline filled while not busy");

endmodule

// ===== bench/tuner_rf_tune_sequence_core_test.sv =====
// Self-checking testbench for the RF tune sequence core.
`timescale 1ns / 1ps

module tuner_rf_tune_sequence_core_test;

	localparam int RESET_CYCLES = 12;
	localparam int STALL_LIMIT  = 1000;   // cycles with neither an item taken nor a write
	localparam int SETTLE_CYCLES = 20;    // latency plus a full sequence
	localparam int RANDOM_ITEMS = 255;
	localparam int NUM_SPURS    = 17;
	localparam int unsigned HZ_IN_MHZ = 1000000;

	// One expected register write
	typedef struct {
		logic [tunrf_pkg::BYTE_W-1:0] addr;
		logic [tunrf_pkg::BYTE_W-1:0] value;
		logic                         hit;
		logic                         last;
	} tune_write_t;

	// Spur window as given in kHz
	typedef struct packed {
		logic [31:0]                  center_khz;
		logic [31:0]                  offset_khz;
		logic [tunrf_pkg::BYTE_W-1:0] val;
		logic [tunrf_pkg::BYTE_W-1:0] dir;
	} spur_zone_t;

	// Directed row; typed rows carry their word and spur bytes
	typedef struct {
		logic [tunrf_pkg::FREQ_W-1:0] freq;
		bit                           typed;
		logic [tunrf_pkg::WORD_W-1:0] word;
		logic [tunrf_pkg::BYTE_W-1:0] sval;
		logic [tunrf_pkg::BYTE_W-1:0] sdir;
		bit                           hit;
	} tune_case_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [tunrf_pkg::FREQ_W-1:0] rf_freq_hz;
	logic                         strobe;
	logic [tunrf_pkg::BYTE_W-1:0] reg_address;
	logic [tunrf_pkg::BYTE_W-1:0] reg_value;
	logic                         spur_hit;
	logic                         last;

	tune_write_t pending_writes[$];
	tune_case_t  tune_cases[$];
	int          mismatches = 0;
	int          stall_cycles = 0;

	tuner_rf_tune_sequence_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.rf_freq_hz  (rf_freq_hz),
		.strobe      (strobe),
		.reg_address (reg_address),
		.reg_value   (reg_value),
		.spur_hit    (spur_hit),
		.last        (last)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Spur windows in search order
	function automatic spur_zone_t spur_zone(int idx);
		spur_zone_t z;
		z = '0;
		case (idx)
			0:  z = {32'd64500,  32'd500, 8'h92, 8'h07};
			1:  z = {32'd191500, 32'd300, 8'hE2, 8'h07};
			2:  z = {32'd205500, 32'd500, 8'h2C, 8'h04};
			3:  z = {32'd212500, 32'd500, 8'h1E, 8'h04};
			4:  z = {32'd226500, 32'd500, 8'hD4, 8'h07};
			5:  z = {32'd99143,  32'd500, 8'h9C, 8'h07};
			6:  z = {32'd173143, 32'd500, 8'hD4, 8'h07};
			7:  z = {32'd191143, 32'd300, 8'hD4, 8'h07};
			8:  z = {32'd207143, 32'd500, 8'hCE, 8'h07};
			9:  z = {32'd225143, 32'd500, 8'hCE, 8'h07};
			10: z = {32'd243143, 32'd500, 8'hD4, 8'h07};
			11: z = {32'd261143, 32'd500, 8'hD4, 8'h07};
			12: z = {32'd291143, 32'd500, 8'hD4, 8'h07};
			13: z = {32'd339143, 32'd500, 8'h2C, 8'h04};
			14: z = {32'd117143, 32'd500, 8'h7A, 8'h07};
			15: z = {32'd135143, 32'd300, 8'h7A, 8'h07};
			16: z = {32'd153143, 32'd500, 8'h01, 8'h07};
			default: ;
		endcase
		return z;
	endfunction

	// Queue the ten writes of one tune sequence
	function automatic void push_sequence(logic [tunrf_pkg::WORD_W-1:0] word,
			logic [tunrf_pkg::BYTE_W-1:0] sval, logic [tunrf_pkg::BYTE_W-1:0] dir_byte,
			logic hit);
		logic [tunrf_pkg::BYTE_W-1:0] addr [tunrf_pkg::WRITES];
		logic [tunrf_pkg::BYTE_W-1:0] value [tunrf_pkg::WRITES];
		tune_write_t                  w;
		addr[0] = tunrf_pkg::ADDR_TUNE_CTRL; value[0] = tunrf_pkg::VAL_ABORT;
		addr[1] = tunrf_pkg::ADDR_SYN_CFG;   value[1] = tunrf_pkg::VAL_CFG_A;
		addr[2] = tunrf_pkg::ADDR_SYN_CFG;   value[2] = tunrf_pkg::VAL_CFG_B;
		addr[3] = tunrf_pkg::ADDR_SYN_MODE;  value[3] = tunrf_pkg::VAL_MODE;
		addr[4] = tunrf_pkg::ADDR_SYN_DIV;   value[4] = tunrf_pkg::VAL_DIV;
		addr[5] = tunrf_pkg::ADDR_SPUR_VAL;  value[5] = sval;
		addr[6] = tunrf_pkg::ADDR_SPUR_DIR;  value[6] = dir_byte;
		addr[7] = tunrf_pkg::ADDR_WORD_LO;   value[7] = word[7:0];
		addr[8] = tunrf_pkg::ADDR_WORD_HI;   value[8] = word[15:8];
		addr[9] = tunrf_pkg::ADDR_TUNE_CTRL; value[9] = tunrf_pkg::VAL_START;
		for (int k = 0; k < tunrf_pkg::WRITES; k++) begin
			w.addr  = addr[k];
			w.value = value[k];
			w.hit   = hit;
			w.last  = (k == tunrf_pkg::WRITES - 1);
			pending_writes.push_back(w);
		end
	endfunction

	// Synthesizer word and spur bytes for one frequency
	function automatic void predict_tune(logic [tunrf_pkg::FREQ_W-1:0] f);
		int unsigned                  rem;
		int unsigned                  thr;
		logic [31:0]                  word;
		logic [tunrf_pkg::BYTE_W-1:0] sval;
		logic [tunrf_pkg::BYTE_W-1:0] sdir;
		logic                         hit;
		spur_zone_t                   z;
		longint unsigned              lo;
		longint unsigned              hi;
		int                           n;
		word = f / HZ_IN_MHZ;
		rem  = f % HZ_IN_MHZ;
		thr  = HZ_IN_MHZ;
		// six fractional bits by halving thresholds
		for (int k = 0; k < tunrf_pkg::FRAC_W; k++) begin
			word = word << 1;
			thr  = thr / 2;
			if (rem > thr) begin
				rem  = rem - thr;
				word = word + 1;
			end
		end
		if (rem > tunrf_pkg::ROUND_THR)
			word = word + 1;
		// first window holding the frequency wins
		sval = tunrf_pkg::VAL_NO_SPUR;
		sdir = '0;
		hit  = 1'b0;
		n = (tunrf_pkg::SPUR_ENTRIES < NUM_SPURS) ? tunrf_pkg::SPUR_ENTRIES : NUM_SPURS;
		for (int k = 0; k < n; k++) begin
			z  = spur_zone(k);
			lo = longint'(z.center_khz - z.offset_khz) * 1000;
			hi = longint'(z.center_khz + z.offset_khz) * 1000;
			if (!hit && f >= lo && f <= hi) begin
				sval = z.val;
				sdir = z.dir;
				hit  = 1'b1;
			end
		end
		push_sequence(word[tunrf_pkg::WORD_W-1:0], sval, tunrf_pkg::VAL_DIR_BASE | sdir, hit);
	endfunction

	function automatic void add_case(logic [tunrf_pkg::FREQ_W-1:0] freq, bit typed,
			logic [tunrf_pkg::WORD_W-1:0] word, logic [tunrf_pkg::BYTE_W-1:0] sval,
			logic [tunrf_pkg::BYTE_W-1:0] sdir, bit hit);
		tune_case_t c;
		c.freq  = freq;
		c.typed = typed;
		c.word  = word;
		c.sval  = sval;
		c.sdir  = sdir;
		c.hit   = hit;
		tune_cases.push_back(c);
	endfunction

	// Random frequency: spur window edges, remainder edges, or anywhere
	function automatic logic [tunrf_pkg::FREQ_W-1:0] random_freq();
		spur_zone_t                   z;
		int unsigned                  lo;
		int unsigned                  hi;
		int unsigned                  rem;
		logic [tunrf_pkg::FREQ_W-1:0] f;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				z  = spur_zone($urandom_range(0, NUM_SPURS - 1));
				lo = (z.center_khz - z.offset_khz) * 1000;
				hi = (z.center_khz + z.offset_khz) * 1000;
				case ($urandom_range(0, 2))
					0:       f = tunrf_pkg::FREQ_W'(lo + $urandom_range(0, 4) - 2);
					1:       f = tunrf_pkg::FREQ_W'(hi + $urandom_range(0, 4) - 2);
					default: f = tunrf_pkg::FREQ_W'(lo + $urandom_range(0, hi - lo));
				endcase
			end
			4, 5: begin
				case ($urandom_range(0, 9))
					0: rem = 0;
					1: rem = 7812;
					2: rem = 7813;
					3: rem = 15625;
					4: rem = 15625 + 7813;
					5: rem = 500000;
					6: rem = 500001;
					7: rem = 999999;
					8: rem = 31250 + $urandom_range(0, 2);
					default: rem = $urandom_range(0, 999999);
				endcase
				f = tunrf_pkg::FREQ_W'($urandom_range(0, 999) * HZ_IN_MHZ + rem);
			end
			6, 7, 8: f = tunrf_pkg::FREQ_W'($urandom_range(0, 999999999));
			default: f = tunrf_pkg::FREQ_W'($urandom);
		endcase
		return f;
	endfunction

	// Present one frequency, with an optional idle burst first
	task automatic send_freq(logic [tunrf_pkg::FREQ_W-1:0] f, int idle_pct);
		int gap;
		gap = 0;
		if ($urandom_range(1, 100) <= idle_pct)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			start      <= 1'b0;
			rf_freq_hz <= tunrf_pkg::FREQ_W'($urandom);
			// sometimes let the current sequence run out before the burst
			if ($urandom_range(0, 1)) begin
				do @(negedge clk); while (busy);
				@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		rf_freq_hz <= f;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// Hold off until every queued write has come out
	task automatic drain_writes();
		start <= 1'b0;
		while (pending_writes.size() > 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Compare each write with the oldest expectation
	always @(negedge clk) begin
		tune_write_t w;
		if (arst_n && strobe) begin
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected write addr=%02h value=%02h hit=%b last=%b",
						$realtime, reg_address, reg_value, spur_hit, last);
			end else begin
				w = pending_writes.pop_front();
				if (reg_address !== w.addr || reg_value !== w.value || spur_hit !== w.hit ||
						last !== w.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("%0t: write mismatch exp addr=%02h value=%02h hit=%b last=%b",
							$realtime, w.addr, w.value, w.hit, w.last);
						$display(" got addr=%02h value=%02h hit=%b last=%b",
							reg_address, reg_value, spur_hit, last);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no progress
	always @(negedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int pct;
		arst_n     = 1'b0;
		start      = 1'b0;
		rf_freq_hz = '0;

		// extremes, spur window bounds, overlaps and rounding edges
		add_case(30'd0,          1'b1, 16'h0000, 8'h00, 8'h00, 1'b0);
		add_case(30'd999999999,  1'b1, 16'hFA00, 8'h00, 8'h00, 1'b0);
		add_case(30'h3FFFFFFF,   1'b1, 16'h0C6F, 8'h00, 8'h00, 1'b0);
		add_case(30'd63999999,   1'b1, 16'h1000, 8'h00, 8'h00, 1'b0);
		add_case(30'd64000000,   1'b1, 16'h1000, 8'h92, 8'h07, 1'b1);
		add_case(30'd65000000,   1'b1, 16'h1040, 8'h92, 8'h07, 1'b1);
		add_case(30'd65000001,   1'b1, 16'h1040, 8'h00, 8'h00, 1'b0);
		add_case(30'd7812,       1'b0, '0, '0, '0, 1'b0);
		add_case(30'd7813,       1'b0, '0, '0, '0, 1'b0);
		add_case(30'd15625,      1'b0, '0, '0, '0, 1'b0);
		add_case(30'd15626,      1'b0, '0, '0, '0, 1'b0);
		add_case(30'd500000,     1'b0, '0, '0, '0, 1'b0);
		add_case(30'd500001,     1'b0, '0, '0, '0, 1'b0);
		add_case(30'd999999,     1'b0, '0, '0, '0, 1'b0);
		add_case(30'd191200000,  1'b0, '0, '0, '0, 1'b0);  // two windows overlap, first wins
		add_case(30'd191443000,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd190843000,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd191800001,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd135443000,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd339643000,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd338642999,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd153143000,  1'b0, '0, '0, '0, 1'b0);
		add_case(30'd98643000,   1'b0, '0, '0, '0, 1'b0);
		add_case(30'h20000000,   1'b0, '0, '0, '0, 1'b0);
		add_case(30'h2AAAAAAA,   1'b0, '0, '0, '0, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tune_cases[i]) begin
			if (tune_cases[i].typed)
				push_sequence(tune_cases[i].word, tune_cases[i].sval,
					tunrf_pkg::VAL_DIR_BASE | tune_cases[i].sdir, tune_cases[i].hit);
			else
				predict_tune(tune_cases[i].freq);
			send_freq(tune_cases[i].freq, 40);
		end
		drain_writes();

		// random phase; idle bursts in places, none at the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			logic [tunrf_pkg::FREQ_W-1:0] f;
			if (i == 160)
				drain_writes();
			pct = (i < 80) ? 50 : (i < 160) ? 0 : (i < 230) ? 35 : 0;
			f = random_freq();
			predict_tune(f);
			send_freq(f, pct);
		end
		drain_writes();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_writes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
